[sv/rlsd_pkg.sv]
// ----------------------------------------------------------------------------
// rlsd_pkg
// Shared constants, types and helpers for the residual LUT scoring block.
// ----------------------------------------------------------------------------
package rlsd_pkg;

    localparam int DIMS        = 128;
    localparam int QUERY_SLOTS = 4;
    localparam int TABLE_ROW   = DIMS * 16;
    localparam int TABLE_DEPTH = QUERY_SLOTS * TABLE_ROW;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int SLOT_W      = (QUERY_SLOTS > 1) ? $clog2(QUERY_SLOTS) : 1;
    localparam int CHUNKS_4    = (DIMS * 4 + 63) / 64;
    localparam int CHUNKS_2    = (DIMS * 2 + 63) / 64;
    localparam int CP_W        = (CHUNKS_4 > 1) ? $clog2(CHUNKS_4) : 1;
    localparam int DIM_W       = CP_W + 5;
    localparam int ACC_W       = 40;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_CHUNK = 2'd2,
        OP_END   = 2'd3
    } t_opcode;

    localparam logic KIND_CAND  = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > ACC_W'(64'sd2147483647))
            r = 32'sh7FFFFFFF;
        else if (v < -ACC_W'(64'sd2147483648))
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Slot number reduced into the range of configured slots
    function automatic logic [SLOT_W-1:0] slot_wrap(input logic [1:0] s);
        int v;
        v = int'(s);
        for (int i = 0; i < 4; i++) begin
            if (v >= QUERY_SLOTS)
                v = v - QUERY_SLOTS;
        end
        return SLOT_W'(v);
    endfunction

endpackage

[sv/rlsd_table.sv]
// ----------------------------------------------------------------------------
// rlsd_table
// Score table: single port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module rlsd_table
    import rlsd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [ADDR_W-1:0]        i_addr,
    input  logic signed [31:0]       i_wdata,
    output logic signed [31:0]       o_rdata
);

    logic signed [31:0] r_mem [TABLE_DEPTH];
    logic signed [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_addr] <= i_wdata;
        if (i_re)
            r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/residual_lut_score_dedup.sv]
// ----------------------------------------------------------------------------
// residual_lut_score_dedup
// Scores packed residual codes against a bucket score table and keeps the
// best score per run of equal ids, emitting candidates and cell run counts.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  --------+-----------+------------------------------------------------------
//  in      | sink      | i_in_valid / o_in_ready, opcode, slot, index, value..
//  out     | source    | o_out_valid / i_out_ready, kind, id, score, total, last
//  cfg     | sink      | i_cfg_valid / o_cfg_ready, i_cfg_code_width_mode
//
//  Load and begin requests complete on acceptance. A residual chunk takes one
//  table read per code through the single RAM port, then a drain and a sum
//  step; the final chunk of a residual adds a score step.
//  End cell emits any held candidate, then the count; output stalls hold it.
//  Results wait in an output register; a stalled output blocks only the
//  requests that must emit. Config is taken only while idle.
//  Reset is synchronous; the table is not cleared.
// ----------------------------------------------------------------------------
module residual_lut_score_dedup
    import rlsd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic [1:0]         i_query_slot,
    input  logic [10:0]        i_table_index,
    input  logic signed [31:0] i_value,
    input  logic [30:0]        i_item_id,
    input  logic [63:0]        i_residual_chunk,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_kind,
    output logic [30:0]        o_out_id,
    output logic signed [31:0] o_out_score,
    output logic [15:0]        o_run_total,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_code_width_mode
);

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_DRAIN, S_SUM, S_SCORE, S_EMIT_C, S_EMIT_N
    } t_state;

    t_state                    r_state;
    logic                      r_mode;
    logic [SLOT_W-1:0]         r_slot;
    logic signed [31:0]        r_base;
    logic signed [31:0]        r_partial;
    logic [CP_W-1:0]           r_pos;
    logic [30:0]               r_held_id;
    logic signed [31:0]        r_held_score;
    logic                      r_held_valid;
    logic [15:0]               r_runs;
    logic [63:0]               r_chunk;
    logic [30:0]               r_id;
    logic [4:0]                r_j;
    logic                      r_hit;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_out_valid;
    logic                      r_kind;
    logic [30:0]               r_out_id;
    logic signed [31:0]        r_out_score;
    logic [15:0]               r_run_total;
    logic                      r_last;

    logic                      in_acc;
    logic                      out_free;
    logic                      out_load;
    logic [2:0]                lk_k;
    logic [7:0]                lk_byte;
    logic [3:0]                lk_code;
    logic [DIM_W-1:0]          lk_dim;
    logic                      lk_ok;
    logic [ADDR_W-1:0]         lk_addr;
    logic [ADDR_W-1:0]         ld_addr;
    logic                      ld_ok;
    logic                      tbl_we;
    logic                      tbl_re;
    logic signed [31:0]        tbl_rdata;
    logic signed [31:0]        n_partial;
    logic signed [31:0]        n_score;
    logic [CP_W:0]             pos_next;
    logic [CP_W:0]             chunks_n;
    logic                      new_run;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // Lookup j: 4-bit mode has two codes per byte, 2-bit mode four (MS field first)
    always_comb begin
        lk_k    = r_mode ? r_j[3:1] : r_j[4:2];
        lk_byte = r_chunk[8*lk_k +: 8];
        if (r_mode) begin
            lk_code = r_j[0] ? lk_byte[3:0] : lk_byte[7:4];
            lk_dim  = {1'b0, r_pos, r_j[3:0]};
        end else begin
            case (r_j[1:0])
                2'd0:    lk_code = {2'b00, lk_byte[7:6]};
                2'd1:    lk_code = {2'b00, lk_byte[5:4]};
                2'd2:    lk_code = {2'b00, lk_byte[3:2]};
                default: lk_code = {2'b00, lk_byte[1:0]};
            endcase
            lk_dim = {r_pos, r_j};
        end
        lk_ok   = int'(lk_dim) < DIMS;
        lk_addr = ADDR_W'(ADDR_W'(r_slot) * ADDR_W'(TABLE_ROW)
                  + ADDR_W'(lk_dim) * ADDR_W'(16) + ADDR_W'(lk_code));
    end

    assign ld_ok   = (int'(i_query_slot) < QUERY_SLOTS) && (int'(i_table_index) < TABLE_ROW);
    assign ld_addr = ADDR_W'(ADDR_W'(i_query_slot) * ADDR_W'(TABLE_ROW)
                     + ADDR_W'(i_table_index));
    assign tbl_we  = in_acc && (t_opcode'(i_opcode) == OP_LOAD) && ld_ok;
    assign tbl_re  = (r_state == S_LOOK) && lk_ok;

    rlsd_table u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_re    (tbl_re),
        .i_addr  (tbl_we ? ld_addr : lk_addr),
        .i_wdata (i_value),
        .o_rdata (tbl_rdata)
    );

    assign n_partial = sat32(ACC_W'(r_partial) + r_acc);
    assign n_score   = sat32(ACC_W'(r_base) + ACC_W'(r_partial));
    assign pos_next  = {1'b0, r_pos} + (CP_W+1)'(1);
    assign chunks_n  = r_mode ? (CP_W+1)'(CHUNKS_4) : (CP_W+1)'(CHUNKS_2);
    assign new_run   = !r_held_valid || (r_id != r_held_id);

    // Output register takes a new result in this cycle
    always_comb begin
        case (r_state)
            S_SCORE:  out_load = new_run && r_held_valid && out_free;
            S_EMIT_C: out_load = r_held_valid && out_free;
            S_EMIT_N: out_load = out_free;
            default:  out_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= 1'b1;
            r_slot       <= '0;
            r_base       <= '0;
            r_partial    <= '0;
            r_pos        <= '0;
            r_held_id    <= '0;
            r_held_score <= '0;
            r_held_valid <= 1'b0;
            r_runs       <= '0;
            r_hit        <= 1'b0;
            r_acc        <= '0;
            r_j          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                r_mode <= i_cfg_code_width_mode;
            r_out_valid <= out_load || (r_out_valid && !i_out_ready);
            if (r_hit)
                r_acc <= r_acc + ACC_W'(tbl_rdata);

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (t_opcode'(i_opcode))
                            OP_BEGIN: begin
                                r_slot       <= slot_wrap(i_query_slot);
                                r_base       <= i_value;
                                r_partial    <= '0;
                                r_pos        <= '0;
                                r_held_valid <= 1'b0;
                                r_held_id    <= '0;
                                r_held_score <= '0;
                                r_runs       <= '0;
                            end
                            OP_CHUNK: begin
                                r_chunk <= i_residual_chunk;
                                r_id    <= i_item_id;
                                r_j     <= '0;
                                r_acc   <= '0;
                                r_state <= S_LOOK;
                            end
                            OP_END:  r_state <= S_EMIT_C;
                            default: ;
                        endcase
                    end
                end
                S_LOOK: begin
                    r_hit <= lk_ok;
                    r_j   <= r_j + 5'd1;
                    if (r_j == {~r_mode, 4'hF})
                        r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    r_hit   <= 1'b0;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_partial <= n_partial;
                    if (pos_next >= chunks_n) begin
                        r_pos   <= '0;
                        r_state <= S_SCORE;
                    end else begin
                        r_pos   <= r_pos + CP_W'(1);
                        r_state <= S_IDLE;
                    end
                end
                S_SCORE: begin
                    if (new_run) begin
                        if (!r_held_valid || out_free) begin
                            if (r_held_valid) begin
                                r_kind      <= KIND_CAND;
                                r_out_id    <= r_held_id;
                                r_out_score <= r_held_score;
                                r_run_total <= '0;
                                r_last      <= 1'b1;
                            end
                            r_held_valid <= 1'b1;
                            r_held_id    <= r_id;
                            r_held_score <= n_score;
                            if (r_runs != 16'hFFFF)
                                r_runs <= r_runs + 16'd1;
                            r_partial <= '0;
                            r_state   <= S_IDLE;
                        end
                    end else begin
                        if (n_score > r_held_score)
                            r_held_score <= n_score;
                        r_partial <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                S_EMIT_C: begin
                    if (!r_held_valid) begin
                        r_state <= S_EMIT_N;
                    end else if (out_free) begin
                        r_kind      <= KIND_CAND;
                        r_out_id    <= r_held_id;
                        r_out_score <= r_held_score;
                        r_run_total <= '0;
                        r_last      <= 1'b0;
                        r_state     <= S_EMIT_N;
                    end
                end
                S_EMIT_N: begin
                    if (out_free) begin
                        r_kind       <= KIND_COUNT;
                        r_out_id     <= '0;
                        r_out_score  <= '0;
                        r_run_total  <= r_runs;
                        r_last       <= 1'b1;
                        r_partial    <= '0;
                        r_pos        <= '0;
                        r_held_valid <= 1'b0;
                        r_held_id    <= '0;
                        r_held_score <= '0;
                        r_runs       <= '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_out_id    = r_out_id;
    assign o_out_score = r_out_score;
    assign o_run_total = r_run_total;
    assign o_last      = r_last;

endmodule

[sv/rlsd_checker.sv]
// ----------------------------------------------------------------------------
// rlsd_checker
// Port-level checks for residual_lut_score_dedup, bound to the top level.
// ----------------------------------------------------------------------------
module rlsd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_out_ready,
    input  logic               o_out_valid,
    input  logic               o_kind,
    input  logic [30:0]        o_out_id,
    input  logic signed [31:0] o_out_score,
    input  logic [15:0]        o_run_total,
    input  logic               o_last
);

    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_out_id) && $stable(o_out_score) && $stable(o_run_total)
            && $stable(o_last))
        else $error("stalled result changed");

    // A count result closes the end-cell request and carries no candidate
    a_count_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind |-> o_last && (o_out_id == '0) && (o_out_score == '0))
        else $error("malformed count result");

    a_cand_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_kind |-> (o_run_total == '0))
        else $error("candidate carries run total");

endmodule

bind residual_lut_score_dedup rlsd_checker u_rlsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_ready (i_out_ready),
    .o_out_valid (o_out_valid),
    .o_kind      (o_kind),
    .o_out_id    (o_out_id),
    .o_out_score (o_out_score),
    .o_run_total (o_run_total),
    .o_last      (o_last)
);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for residual_lut_score_dedup. Stimulus codes are kept to
// buckets 0 and 3, and those buckets of slot 0 are preloaded for every
// dimension, so no lookup touches an unloaded entry. A short directed part
// runs next, then random cells in both code widths. An in-bench scoreboard
// predicts candidates and run counts and compares every output field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
    import rlsd_pkg::*;
();

    typedef struct {
        logic        kind;
        logic [30:0] id;
        logic [31:0] score;
        logic [15:0] total;
        logic        last;
    } t_result;

    class dedup_scoreboard;
        logic signed [31:0] score_tab [TABLE_DEPTH];
        logic               wide_codes;
        logic signed [31:0] part_sum;
        int unsigned        chunk_pos;
        int unsigned        slot;
        logic signed [31:0] base_score;
        logic [30:0]        run_id;
        logic signed [31:0] run_best;
        logic               run_open;
        int unsigned        runs;
        t_result            pending_q[$];
        int                 errors;
        int                 n_cand;
        int                 n_count;

        function void reset_state();
            foreach (score_tab[i]) score_tab[i] = '0;
            wide_codes = 1'b1;
            slot = 0;
            base_score = '0;
            clear_cell();
            errors = 0;
        endfunction

        function void clear_cell();
            part_sum = '0;
            chunk_pos = 0;
            run_open = 1'b0;
            run_id = '0;
            run_best = '0;
            runs = 0;
        endfunction

        function logic signed [31:0] clamp(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function longint entry(int unsigned dim, int unsigned code);
            if (dim >= DIMS) return 0;
            return longint'(score_tab[slot * TABLE_ROW + dim * 16 + code]);
        endfunction

        function void push(logic kind, logic [30:0] id, logic [31:0] score,
                           logic [15:0] total);
            t_result r;
            r.kind = kind; r.id = id; r.score = score; r.total = total; r.last = 1'b0;
            pending_q.push_back(r);
        endfunction

        // Predicts the results of one accepted request
        function void note_request(t_opcode op, logic [1:0] qslot, logic [10:0] tidx,
                                   logic signed [31:0] val, logic [30:0] id,
                                   logic [63:0] chunk);
            int          n_prev;
            longint      acc;
            int unsigned nchunks;
            int unsigned b;
            int unsigned bidx;
            logic signed [31:0] s;
            n_prev = pending_q.size();
            case (op)
                OP_LOAD: begin
                    if (qslot < QUERY_SLOTS && tidx < TABLE_ROW)
                        score_tab[qslot * TABLE_ROW + tidx] = val;
                end
                OP_BEGIN: begin
                    slot = qslot % QUERY_SLOTS;
                    base_score = val;
                    clear_cell();
                end
                OP_CHUNK: begin
                    nchunks = wide_codes ? CHUNKS_4 : CHUNKS_2;
                    acc = 0;
                    for (int k = 0; k < 8; k++) begin
                        b = chunk[8*k +: 8];
                        bidx = chunk_pos * 8 + k;
                        if (wide_codes) begin
                            acc += entry(bidx * 2, b >> 4);
                            acc += entry(bidx * 2 + 1, b & 8'h0F);
                        end else begin
                            acc += entry(bidx * 4, (b & 8'hC0) >> 6);
                            acc += entry(bidx * 4 + 1, (b & 8'h30) >> 4);
                            acc += entry(bidx * 4 + 2, (b & 8'h0C) >> 2);
                            acc += entry(bidx * 4 + 3, b & 8'h03);
                        end
                    end
                    part_sum = clamp(longint'(part_sum) + acc);
                    if (chunk_pos + 1 >= nchunks) begin
                        s = clamp(longint'(base_score) + longint'(part_sum));
                        part_sum = '0;
                        chunk_pos = 0;
                        if (!run_open || id != run_id) begin
                            if (run_open) push(KIND_CAND, run_id, run_best, '0);
                            run_open = 1'b1;
                            run_id = id;
                            run_best = s;
                            if (runs < 16'hFFFF) runs++;
                        end else if (s > run_best) begin
                            run_best = s;
                        end
                    end else begin
                        chunk_pos++;
                    end
                end
                default: begin
                    if (run_open) push(KIND_CAND, run_id, run_best, '0);
                    push(KIND_COUNT, '0, '0, runs[15:0]);
                    clear_cell();
                end
            endcase
            if (pending_q.size() > n_prev)
                pending_q[pending_q.size() - 1].last = 1'b1;
        endfunction

        function void check_result(logic kind, logic [30:0] id, logic [31:0] score,
                                   logic [15:0] total, logic last);
            t_result e;
            if (pending_q.size() == 0) begin
                $error("unexpected result kind=%0d id=%0h", kind, id);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (kind == KIND_CAND) n_cand++; else n_count++;
            if (kind !== e.kind) begin
                $error("kind: expected %0d actual %0d", e.kind, kind); errors++;
            end
            if (id !== e.id) begin
                $error("out_id: expected %0h actual %0h", e.id, id); errors++;
            end
            if (score !== e.score) begin
                $error("out_score: expected %0h actual %0h", e.score, score); errors++;
            end
            if (total !== e.total) begin
                $error("run_total: expected %0d actual %0d", e.total, total); errors++;
            end
            if (last !== e.last) begin
                $error("last: expected %0d actual %0d", e.last, last); errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_opcode = '0;
    logic [1:0]         i_query_slot = '0;
    logic [10:0]        i_table_index = '0;
    logic signed [31:0] i_value = '0;
    logic [30:0]        i_item_id = '0;
    logic [63:0]        i_residual_chunk = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_kind;
    logic [30:0]        o_out_id;
    logic signed [31:0] o_out_score;
    logic [15:0]        o_run_total;
    logic               o_last;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_code_width_mode = 1'b1;

    dedup_scoreboard sb = new();
    logic            hold_req = 1'b0;
    logic            hold_done = 1'b0;
    int              n_req = 0;
    logic            cur_wide = 1'b1;

    residual_lut_score_dedup DUT (.*);

    always #2 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("[residual_lut_score_dedup] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_kind, o_out_id, o_out_score, o_run_total, o_last);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // Output back-pressure, with one long hold-off on request
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 3) != 0);
                repeat (pick_gap() + 1) @(posedge i_clk);
            end
        end
    end

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2, 3: return $urandom;
            default: return $signed(32'($urandom_range(0, 32'h1FFFFF))) - 32'sh100000;
        endcase
    endfunction

    // Every nibble is 0x0 or 0x3: codes stay in buckets 0 and 3 in both widths
    function automatic logic [63:0] rand_chunk();
        logic [63:0] c;
        logic [15:0] sel;
        case ($urandom_range(0, 9))
            0: sel = '1;
            1: sel = '0;
            default: sel = 16'($urandom);
        endcase
        c = '0;
        for (int n = 0; n < 16; n++)
            c[4*n +: 4] = sel[n] ? 4'h3 : 4'h0;
        return c;
    endfunction

    task automatic send(t_opcode op, logic [1:0] qslot, logic [10:0] tidx,
                        logic signed [31:0] val, logic [30:0] id, logic [63:0] chunk,
                        bit idle_ok = 1'b1);
        int g;
        g = idle_ok ? pick_gap() : 0;
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_opcode         <= op;
        i_query_slot     <= qslot;
        i_table_index    <= tidx;
        i_value          <= val;
        i_item_id        <= id;
        i_residual_chunk <= chunk;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(op, qslot, tidx, val, id, chunk);
        n_req++;
    endtask

    task automatic send_residual(logic [30:0] id);
        int n;
        n = cur_wide ? CHUNKS_4 : CHUNKS_2;
        for (int c = 0; c < n; c++)
            send(OP_CHUNK, 2'($urandom), 11'($urandom), $urandom,
                 (c == n - 1) ? id : 31'($urandom), rand_chunk());
    endtask

    // Drains outstanding results, then lets an in-flight chunk settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_width(logic wide);
        i_cfg_valid           <= 1'b1;
        i_cfg_code_width_mode <= wide;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.wide_codes = wide;
        cur_wide = wide;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_cell();
        logic [30:0] id;
        int          runs;
        send(OP_BEGIN, 2'd0, 11'($urandom), rand_value(), 31'($urandom), 64'($urandom));
        runs = $urandom_range(1, 3);
        for (int r = 0; r < runs; r++) begin
            id = 31'($urandom);
            repeat ($urandom_range(1, 2)) send_residual(id);
            if ($urandom_range(0, 9) == 0)
                send(OP_LOAD, 2'($urandom), 11'($urandom), rand_value(), 31'($urandom),
                     64'($urandom));
        end
        case ($urandom_range(0, 9))
            0: begin
                // broken residual, then end
                send(OP_CHUNK, 2'($urandom), 11'($urandom), $urandom, 31'($urandom),
                     rand_chunk());
                send(OP_END, 2'($urandom), 11'($urandom), $urandom, 31'($urandom),
                     64'($urandom));
            end
            1: ; // next begin discards this cell
            default: send(OP_END, 2'($urandom), 11'($urandom), $urandom, 31'($urandom),
                          64'($urandom));
        endcase
    endtask

    initial begin
        sb.reset_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // buckets 0 and 3 of slot 0 for every dimension, back to back
        for (int d = 0; d < DIMS; d++) begin
            send(OP_LOAD, 2'd0, 11'(d * 16), rand_value(), 31'($urandom),
                 64'($urandom), 1'b0);
            send(OP_LOAD, 2'd0, 11'(d * 16 + 3), rand_value(), 31'($urandom),
                 64'($urandom), 1'b0);
        end

        // extremes of the table and saturation of the sum
        send(OP_LOAD, 2'd0, 11'd3, 32'sh7FFFFFFF, '0, '0);
        send(OP_LOAD, 2'd0, 11'd2035, 32'sh80000000, '1, '1);
        send(OP_LOAD, 2'd3, 11'd0, 32'sh80000000, '0, '0);
        send(OP_BEGIN, 2'd0, '0, 32'sh7FFFFFFF, '0, '0);
        send_residual('1);
        send_residual('1);
        send_residual('0);
        send(OP_END, 2'd0, '0, '0, '0, '0);
        send(OP_END, 2'd0, '0, '0, '0, '0);        // empty cell
        send(OP_BEGIN, 2'd0, '1, 32'sh80000000, '1, '1);
        send_residual(31'h2AAAAAAA);
        send(OP_BEGIN, 2'd0, '0, '0, '0, '0);      // begin without end
        send_residual(31'h55555555);
        send(OP_CHUNK, 2'd1, '0, '0, '0, rand_chunk());  // partial residual
        send(OP_END, 2'd1, '1, '1, '1, '1);
        send(OP_BEGIN, 2'd0, '0, 32'sd1, '0, '0);
        repeat (5) send(OP_CHUNK, 2'd0, '0, '0, '0, rand_chunk());
        wait_idle();
        write_width(1'b0);                          // narrower mode mid-residual
        send(OP_CHUNK, 2'd0, '0, '0, 31'd7, rand_chunk());
        send_residual(31'd7);
        send(OP_END, 2'd0, '0, '0, '0, '0);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            write_width(ph[0]);
            if (ph == 1) hold_req = 1'b1;
            for (int c = 0; c < 2; c++) random_cell();
            wait_idle();
        end
        write_width(1'b1);

        $display("requests %0d, candidates %0d, run counts %0d", n_req, sb.n_cand,
                 sb.n_count);
        $display("covered both code widths, saturation, id runs and broken cells");
        if (sb.errors == 0)
            $display("[residual_lut_score_dedup] OK");
        else
            $display("[residual_lut_score_dedup] ERROR");
        $finish;
    end

endmodule

[filelist.f]
sv/rlsd_pkg.sv
sv/rlsd_table.sv
sv/residual_lut_score_dedup.sv
sv/rlsd_checker.sv
dv/tb_top.sv
